FILE: sv/pnmrgb_pkg.sv
// shared types, character codes and maxval table for the netpbm to rgb444 stream converter
`timescale 1ns / 1ps

package pnmrgb_pkg;

  localparam int NUMBER_BITS = 16;
  localparam int AccW        = NUMBER_BITS + 4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_MAGIC2,
    PH_WIDTH_PRE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAX_PRE,
    PH_MAXVAL,
    PH_COMMENT_W,
    PH_COMMENT_M,
    PH_DATA
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_MAGIC  = 2'd0;
  localparam logic [1:0] ERR_WIDTH  = 2'd1;
  localparam logic [1:0] ERR_HEIGHT = 2'd2;
  localparam logic [1:0] ERR_MAXVAL = 2'd3;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [2:0] SHIFT_DEFAULT = 3'd4;

  // maxval to nibble shift, anything not listed keeps the default
  function automatic logic [2:0] shift_for_maxval(input logic [NUMBER_BITS-1:0] v);
    logic [2:0] s;
    begin
      s = SHIFT_DEFAULT;
      if (v == NUMBER_BITS'(255)) s = 3'd4;
      if (v == NUMBER_BITS'(127)) s = 3'd3;
      if (v == NUMBER_BITS'(63))  s = 3'd2;
      if (v == NUMBER_BITS'(31))  s = 3'd1;
      if (v == NUMBER_BITS'(15) || v == NUMBER_BITS'(7) || v == NUMBER_BITS'(3)) s = 3'd0;
      return s;
    end
  endfunction

endpackage

FILE: sv/pnm_stream_to_rgb444.sv
// top level: byte stream in, rgb444 pixels or header errors out
`timescale 1ns / 1ps

// Takes a binary netpbm file (P6 colour or P5 grey) one byte per transaction and returns
// one RGB444 pixel per colour triple or grey byte, with last set on the final pixel, or a
// single error transaction (kind 1, last 1) on a bad magic or a bad width, height or maxval
// token. first_byte restarts the parser at any time. The block takes one byte every cycle
// while the result register is not stalled; each byte passes an input register, one step of
// the parser and the result register. The only back pressure is a stalled result register,
// which holds the input register and so stalls the input.
module pnm_stream_to_rgb444 import pnmrgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      step;
  result_t   res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
  end

  pnmrgb_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

`ifndef SYNTH
  // an error transaction always closes the file and carries no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_ERROR |-> out_data_o.last && out_data_o.pixel == '0)
    else $error("error transaction without last or with pixel bits");

  // a pixel transaction carries a zero error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PIXEL |-> out_data_o.error_code == ERR_MAGIC)
    else $error("pixel transaction with nonzero error code");

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register free");

  // a held input byte is stepped once the result side frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty result register");
`endif

endmodule

FILE: sv/pnmrgb_parse.sv
// header parser and pixel packer: one byte per step, at most one result per step
`timescale 1ns / 1ps

module pnmrgb_parse import pnmrgb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output result_t  res_o
);

  phase_e                   phase_q, phase_d;
  logic [NUMBER_BITS-1:0]   acc_q, acc_d;
  logic                     started_q, started_d;
  logic                     colour_q, colour_d;
  logic [NUMBER_BITS-1:0]   width_q, width_d;
  logic [NUMBER_BITS-1:0]   height_q, height_d;
  logic [2:0]               shift_q, shift_d;
  logic [NUMBER_BITS-1:0]   col_q, col_d;
  logic [NUMBER_BITS-1:0]   row_q, row_d;
  logic [1:0]               comp_q, comp_d;
  logic [7:0]               hold_q, hold_d;

  logic [7:0]             c;
  logic                   first;
  logic                   is_ws, is_digit, is_hash, is_eol;
  logic [3:0]             digit_val;
  logic [NUMBER_BITS-1:0] acc_src;
  logic [AccW-1:0]        prod;
  logic                   tok_err, tok_done;
  logic [3:0]             nib;
  logic [NUMBER_BITS-1:0] col_inc, row_inc;
  logic                   col_wrap, row_end, pix_fire;

  assign c         = item_i.byte_in;
  assign first     = item_i.first_byte;
  assign is_ws     = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_digit  = (c >= CH_0) && (c <= CH_9);
  assign is_hash   = (c == CH_HASH);
  assign is_eol    = (c == CH_CR) || (c == CH_LF);
  assign digit_val = 4'(c - CH_0);

  // a token that starts from a whitespace-skip phase begins at zero
  assign acc_src  = (phase_q == PH_WIDTH_PRE || phase_q == PH_MAX_PRE) ? '0 : acc_q;
  assign prod     = AccW'(acc_src) * AccW'(10) + AccW'(digit_val);
  assign tok_err  = !is_ws && (!is_digit || (|prod[AccW-1:NUMBER_BITS]));
  assign tok_done = is_ws && started_q;

  assign nib      = 4'(c >> shift_q);
  assign col_inc  = col_q + NUMBER_BITS'(1);
  assign row_inc  = row_q + NUMBER_BITS'(1);
  assign col_wrap = (col_inc == width_q);
  assign row_end  = col_wrap && (row_inc == height_q);
  assign pix_fire = !first && (phase_q == PH_DATA) && (!colour_q || comp_q == 2'd2);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (first) begin
      phase_d = (c == CH_P) ? PH_MAGIC2 : PH_IDLE;
    end else begin
      unique case (phase_q)
        PH_IDLE: phase_d = PH_IDLE;
        PH_MAGIC2: phase_d = (c == CH_5 || c == CH_6) ? PH_WIDTH_PRE : PH_IDLE;
        PH_WIDTH_PRE, PH_MAX_PRE: begin
          if (is_ws) phase_d = phase_q;
          else if (is_hash) phase_d = (phase_q == PH_WIDTH_PRE) ? PH_COMMENT_W : PH_COMMENT_M;
          else if (is_digit) phase_d = (phase_q == PH_WIDTH_PRE) ? PH_WIDTH : PH_MAXVAL;
          else phase_d = PH_IDLE;
        end
        PH_COMMENT_W: if (is_eol) phase_d = PH_WIDTH;
        PH_COMMENT_M: if (is_eol) phase_d = PH_MAXVAL;
        PH_WIDTH: begin
          if (tok_err) phase_d = PH_IDLE;
          else if (tok_done) phase_d = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          if (tok_err) phase_d = PH_IDLE;
          else if (tok_done) phase_d = PH_MAX_PRE;
        end
        PH_MAXVAL: begin
          if (tok_err) phase_d = PH_IDLE;
          else if (tok_done) begin
            phase_d = (width_q == '0 || height_q == '0) ? PH_IDLE : PH_DATA;
          end
        end
        PH_DATA: if (pix_fire && row_end) phase_d = PH_IDLE;
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath registers and result
  always_comb begin
    acc_d     = acc_q;
    started_d = started_q;
    colour_d  = colour_q;
    width_d   = width_q;
    height_d  = height_q;
    shift_d   = shift_q;
    col_d     = col_q;
    row_d     = row_q;
    comp_d    = comp_q;
    hold_d    = hold_q;
    res_o     = '0;

    if (first) begin
      if (c != CH_P) begin
        res_o.valid           = 1'b1;
        res_o.item.kind       = KIND_ERROR;
        res_o.item.error_code = ERR_MAGIC;
        res_o.item.last       = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_MAGIC2: begin
          if (c == CH_6) colour_d = 1'b1;
          else if (c == CH_5) colour_d = 1'b0;
          else begin
            res_o.valid           = 1'b1;
            res_o.item.kind       = KIND_ERROR;
            res_o.item.error_code = ERR_MAGIC;
            res_o.item.last       = 1'b1;
          end
        end
        PH_WIDTH_PRE, PH_MAX_PRE: begin
          if (!is_ws && !is_hash) begin
            if (is_digit) begin
              acc_d     = prod[NUMBER_BITS-1:0];
              started_d = 1'b1;
            end else begin
              res_o.valid           = 1'b1;
              res_o.item.kind       = KIND_ERROR;
              res_o.item.error_code = (phase_q == PH_WIDTH_PRE) ? ERR_WIDTH : ERR_MAXVAL;
              res_o.item.last       = 1'b1;
            end
          end
        end
        PH_COMMENT_W, PH_COMMENT_M: begin
          if (is_eol) begin
            acc_d     = '0;
            started_d = 1'b0;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (tok_err) begin
            res_o.valid     = 1'b1;
            res_o.item.kind = KIND_ERROR;
            res_o.item.last = 1'b1;
            priority if (phase_q == PH_WIDTH) res_o.item.error_code = ERR_WIDTH;
            else if (phase_q == PH_HEIGHT) res_o.item.error_code = ERR_HEIGHT;
            else res_o.item.error_code = ERR_MAXVAL;
          end else if (is_digit) begin
            acc_d     = prod[NUMBER_BITS-1:0];
            started_d = 1'b1;
          end else if (tok_done) begin
            priority if (phase_q == PH_WIDTH) begin
              width_d   = acc_q;
              acc_d     = '0;
              started_d = 1'b0;
            end else if (phase_q == PH_HEIGHT) begin
              height_d = acc_q;
            end else begin
              shift_d = shift_for_maxval(acc_q);
              col_d   = '0;
              row_d   = '0;
              comp_d  = 2'd0;
              hold_d  = '0;
            end
          end
        end
        PH_DATA: begin
          if (colour_q) begin
            unique case (comp_q)
              2'd0: begin
                hold_d = {nib, 4'b0000};
                comp_d = 2'd1;
              end
              2'd1: begin
                hold_d = {hold_q[7:4], nib};
                comp_d = 2'd2;
              end
              default: comp_d = 2'd0;
            endcase
          end
          if (pix_fire) begin
            res_o.valid       = 1'b1;
            res_o.item.kind   = KIND_PIXEL;
            res_o.item.pixel  = colour_q ? {hold_q, nib} : {nib, nib, nib};
            res_o.item.last   = row_end;
            if (col_wrap) begin
              col_d = '0;
              row_d = row_inc;
            end else begin
              col_d = col_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      acc_q     <= '0;
      started_q <= 1'b0;
      colour_q  <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
      shift_q   <= SHIFT_DEFAULT;
      col_q     <= '0;
      row_q     <= '0;
      comp_q    <= 2'd0;
      hold_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      started_q <= started_d;
      colour_q  <= colour_d;
      width_q   <= width_d;
      height_q  <= height_d;
      shift_q   <= shift_d;
      col_q     <= col_d;
      row_q     <= row_d;
      comp_q    <= comp_d;
      hold_q    <= hold_d;
    end
  end

endmodule
